// ===== rtl/core/cotp_pkg.sv =====
// Shared types, constants and arithmetic helpers for the octagonal prism triangle unit.
`timescale 1ns / 1ps

package cotp_pkg;

   localparam int MAX_TRIANGLES = 1024;
   localparam int WORLD_SCALE   = 4;

   localparam int TRI_PER_CYL = 16;
   localparam int STEP_W      = $clog2(TRI_PER_CYL);
   localparam int COUNT_W     = 11;
   localparam int INDEX_W     = 10;
   localparam int COORD_W     = 20;
   localparam int CENTER_W    = 16;
   localparam int HEIGHT_W    = 18;
   localparam int WIDE_W      = 40;

   localparam int Q16_DIAG = 46341;

   localparam logic CMD_CLEAR = 1'b0;
   localparam logic CMD_ADD   = 1'b1;

   // unit direction component codes
   localparam logic [2:0] DIR_ZERO     = 3'd0;
   localparam logic [2:0] DIR_ONE      = 3'd1;
   localparam logic [2:0] DIR_DIAG     = 3'd2;
   localparam logic [2:0] DIR_NEG_ONE  = 3'd3;
   localparam logic [2:0] DIR_NEG_DIAG = 3'd4;

   localparam logic [2:0] DIR_X [8] = '{DIR_ONE, DIR_DIAG, DIR_ZERO, DIR_NEG_DIAG,
                                        DIR_NEG_ONE, DIR_NEG_DIAG, DIR_ZERO, DIR_DIAG};
   localparam logic [2:0] DIR_Z [8] = '{DIR_ZERO, DIR_DIAG, DIR_ONE, DIR_DIAG,
                                        DIR_ZERO, DIR_NEG_DIAG, DIR_NEG_ONE, DIR_NEG_DIAG};

   typedef struct packed {
      logic signed [CENTER_W-1:0] cx;
      logic signed [CENTER_W-1:0] cz;
      logic signed [HEIGHT_W-1:0] y_lo;
      logic signed [HEIGHT_W-1:0] y_hi;
      logic signed [CENTER_W-1:0] radius;
      logic [INDEX_W-1:0]         base;
      logic [STEP_W-1:0]          step;
   } work_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        tri_index;
      logic signed [COORD_W-1:0] v0_x;
      logic signed [COORD_W-1:0] v0_y;
      logic signed [COORD_W-1:0] v0_z;
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_y;
      logic signed [COORD_W-1:0] v1_z;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_y;
      logic signed [COORD_W-1:0] v2_z;
      logic                      last;
   } tri_type;

   function automatic logic signed [COORD_W-1:0] sat_f(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'((1 <<< (COORD_W - 1)) - 1);
      lo = -WIDE_W'(1 <<< (COORD_W - 1));
      if (v > hi) begin
         return COORD_W'(hi);
      end else if (v < lo) begin
         return COORD_W'(lo);
      end
      return COORD_W'(v);
   endfunction

   function automatic logic signed [COORD_W-1:0] scale_y_f(
      input logic signed [HEIGHT_W-1:0] y);
      return sat_f(WIDE_W'(y) * WIDE_W'(WORLD_SCALE));
   endfunction

   // (c * 2^16 + d * r) * scale / 2^16, truncated toward zero
   function automatic logic signed [COORD_W-1:0] corner_f(
      input logic signed [CENTER_W-1:0] c,
      input logic [2:0]                 dsel,
      input logic signed [CENTER_W-1:0] r,
      input logic signed [WIDE_W-1:0]   p_diag);
      logic signed [WIDE_W-1:0] term;
      logic signed [WIDE_W-1:0] s;
      logic signed [WIDE_W-1:0] q;
      logic signed [WIDE_W-1:0] t;
      case (dsel)
         DIR_ONE:      term = WIDE_W'(r) <<< 16;
         DIR_NEG_ONE:  term = -(WIDE_W'(r) <<< 16);
         DIR_DIAG:     term = p_diag;
         DIR_NEG_DIAG: term = -p_diag;
         default:      term = '0;
      endcase
      s = (WIDE_W'(c) <<< 16) + term;
      q = s * WIDE_W'(WORLD_SCALE);
      if (q < 0) begin
         t = (q + WIDE_W'(65535)) >>> 16;
      end else begin
         t = q >>> 16;
      end
      return sat_f(t);
   endfunction

endpackage

// ===== rtl/core/cotp_ctrl.sv =====
// Request intake, running triangle count and per-cylinder step sequencer.
`timescale 1ns / 1ps

module cotp_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic signed [cotp_pkg::CENTER_W-1:0] req_center_x,
   input  logic signed [cotp_pkg::CENTER_W-1:0] req_center_z,
   input  logic signed [cotp_pkg::HEIGHT_W-1:0] req_bottom_y,
   input  logic signed [cotp_pkg::HEIGHT_W-1:0] req_top_y,
   input  logic signed [cotp_pkg::CENTER_W-1:0] req_radius,
   input  logic                            out_ready,
   output logic                            work_valid,
   output cotp_pkg::work_type              work
);
   import cotp_pkg::*;

   logic                 work_valid_ff, work_valid_in;
   work_type             work_ff, work_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 load;
   logic                 fire;
   logic                 done;
   logic                 add_ok;
   logic [COUNT_W:0]     count_next_sum;

   assign fire      = work_valid_ff && out_ready;
   assign done      = fire && (work_ff.step == STEP_W'(TRI_PER_CYL - 1));
   assign req_stall = work_valid_ff && !done;
   assign load      = req_valid && !req_stall;

   assign count_next_sum = {1'b0, count_ff} + (COUNT_W + 1)'(TRI_PER_CYL);
   assign add_ok = (req_command == CMD_ADD) && (req_radius > 0)
                   && !(count_next_sum > (COUNT_W + 1)'(MAX_TRIANGLES));

   always_comb begin
      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      count_in      = count_ff;
      if (fire) begin
         work_in.step = work_ff.step + 1'b1;
      end
      if (done) begin
         work_valid_in = 1'b0;
      end
      if (load) begin
         if (req_command == CMD_CLEAR) begin
            count_in = '0;
         end else if (add_ok) begin
            count_in       = count_next_sum[COUNT_W-1:0];
            work_valid_in  = 1'b1;
            work_in.cx     = req_center_x;
            work_in.cz     = req_center_z;
            work_in.y_lo   = req_bottom_y;
            work_in.y_hi   = req_top_y;
            work_in.radius = req_radius;
            work_in.base   = count_ff[INDEX_W-1:0];
            work_in.step   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         count_ff      <= '0;
         work_ff       <= '0;
      end else begin
         work_valid_ff <= work_valid_in;
         count_ff      <= count_in;
         work_ff       <= work_in;
      end
   end

   assign work_valid = work_valid_ff;
   assign work       = work_ff;

endmodule

// ===== rtl/core/cotp_geom.sv =====
// Builds one wall triangle of the prism from the current cylinder and step.
`timescale 1ns / 1ps

module cotp_geom (
   input  cotp_pkg::work_type work,
   output cotp_pkg::tri_type  tri_out
);
   import cotp_pkg::*;

   logic [2:0]                k0, k1;
   logic signed [WIDE_W-1:0]  p_diag;
   logic signed [COORD_W-1:0] x0, z0, x1, z1, y_lo, y_hi;

   assign k0 = work.step[STEP_W-1:1];
   assign k1 = k0 + 3'd1;

   // radius times the Q16 diagonal, shared by all diagonal corners
   assign p_diag = WIDE_W'(work.radius) * WIDE_W'(Q16_DIAG);

   assign x0   = corner_f(work.cx, DIR_X[k0], work.radius, p_diag);
   assign z0   = corner_f(work.cz, DIR_Z[k0], work.radius, p_diag);
   assign x1   = corner_f(work.cx, DIR_X[k1], work.radius, p_diag);
   assign z1   = corner_f(work.cz, DIR_Z[k1], work.radius, p_diag);
   assign y_lo = scale_y_f(work.y_lo);
   assign y_hi = scale_y_f(work.y_hi);

   always_comb begin
      tri_out.tri_index = work.base + INDEX_W'(work.step);
      tri_out.last      = (work.step == STEP_W'(TRI_PER_CYL - 1));
      tri_out.v0_x      = x1;
      tri_out.v0_y      = y_lo;
      tri_out.v0_z      = z1;
      if (!work.step[0]) begin
         // bottom right, bottom left, top left
         tri_out.v1_x = x0;
         tri_out.v1_y = y_lo;
         tri_out.v1_z = z0;
         tri_out.v2_x = x0;
         tri_out.v2_y = y_hi;
         tri_out.v2_z = z0;
      end else begin
         // bottom right, top left, top right
         tri_out.v1_x = x0;
         tri_out.v1_y = y_hi;
         tri_out.v1_z = z0;
         tri_out.v2_x = x1;
         tri_out.v2_y = y_hi;
         tri_out.v2_z = z1;
      end
   end

endmodule

// ===== rtl/core/cylinder_to_octagonal_prism_triangles_unit.sv =====
// Cylinder to octagonal prism triangle unit: top level with result register.
//
// Request channel (req_*): one transaction per command. Command CMD_CLEAR
// zeroes the running triangle count; CMD_ADD turns one vertical cylinder
// into 16 outward-wound wall triangles of an eight-sided prism.
// Result channel (rsp_*): one triangle per transaction, tagged with its slot
// in the surface store; rsp_last marks the sixteenth triangle of a prism.
// A cylinder with radius <= 0, or one that would push the count past
// MAX_TRIANGLES, is taken and dropped without results.
// The request is registered in the sequencer, and each triangle in turn in
// the result register. One triangle per cycle while the receiver does not
// stall, set by the single triangle builder that walks the prism one step per
// cycle; a clear or dropped request yields no triangles. The next request is taken in the
// cycle the last triangle enters the result register, so prisms stream out
// with no gap.
// Reset (synchronous) clears the count, the sequencer and rsp_valid.
// When the receiver stalls, the result register holds its triangle, the
// sequencer waits and req_stall stays high until the prism is finished.
`timescale 1ns / 1ps

module cylinder_to_octagonal_prism_triangles_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_command,
   input  logic signed [cotp_pkg::CENTER_W-1:0]  req_center_x,
   input  logic signed [cotp_pkg::CENTER_W-1:0]  req_center_z,
   input  logic signed [cotp_pkg::HEIGHT_W-1:0]  req_bottom_y,
   input  logic signed [cotp_pkg::HEIGHT_W-1:0]  req_top_y,
   input  logic signed [cotp_pkg::CENTER_W-1:0]  req_radius,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [cotp_pkg::INDEX_W-1:0]          rsp_tri_index,
   output logic signed [cotp_pkg::COORD_W-1:0]   rsp_v0_x,
   output logic signed [cotp_pkg::COORD_W-1:0]   rsp_v0_y,
   output logic signed [cotp_pkg::COORD_W-1:0]   rsp_v0_z,
   output logic signed [cotp_pkg::COORD_W-1:0]   rsp_v1_x,
   output logic signed [cotp_pkg::COORD_W-1:0]   rsp_v1_y,
   output logic signed [cotp_pkg::COORD_W-1:0]   rsp_v1_z,
   output logic signed [cotp_pkg::COORD_W-1:0]   rsp_v2_x,
   output logic signed [cotp_pkg::COORD_W-1:0]   rsp_v2_y,
   output logic signed [cotp_pkg::COORD_W-1:0]   rsp_v2_z,
   output logic                                  rsp_last
);
   import cotp_pkg::*;

   logic     out_ready;
   logic     work_valid;
   work_type work;
   tri_type  tri_next;
   logic     rsp_valid_ff, rsp_valid_in;
   tri_type  rsp_ff, rsp_in;

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   cotp_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_center_x (req_center_x),
      .req_center_z (req_center_z),
      .req_bottom_y (req_bottom_y),
      .req_top_y    (req_top_y),
      .req_radius   (req_radius),
      .out_ready    (out_ready),
      .work_valid   (work_valid),
      .work         (work)
   );

   cotp_geom u_geom (
      .work    (work),
      .tri_out (tri_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_ready) begin
         rsp_valid_in = work_valid;
         rsp_in       = tri_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tri_index = rsp_ff.tri_index;
   assign rsp_v0_x      = rsp_ff.v0_x;
   assign rsp_v0_y      = rsp_ff.v0_y;
   assign rsp_v0_z      = rsp_ff.v0_z;
   assign rsp_v1_x      = rsp_ff.v1_x;
   assign rsp_v1_y      = rsp_ff.v1_y;
   assign rsp_v1_z      = rsp_ff.v1_z;
   assign rsp_v2_x      = rsp_ff.v2_x;
   assign rsp_v2_y      = rsp_ff.v2_y;
   assign rsp_v2_z      = rsp_ff.v2_z;
   assign rsp_last      = rsp_ff.last;

   // prisms start on a 16-aligned slot, so the last triangle ends one
   a_last_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_tri_index[STEP_W-1:0] == STEP_W'(TRI_PER_CYL - 1))
      else $error("last triangle not at end of aligned slot group");

   // within a prism, triangles follow with no gap and consecutive slots
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && rsp_tri_index == $past(rsp_tri_index) + INDEX_W'(1))
      else $error("gap or slot skip inside a prism");

   // a request is never taken while a prism's non-final triangle waits
   a_hold_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && !rsp_last |-> req_stall)
      else $error("request taken while prism unfinished");

endmodule

// ===== verif/tb.sv =====
// Testbench for the cylinder to octagonal prism triangle unit: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb;
   import cotp_pkg::*;

   localparam int RANDOM_ADDS     = 150;
   localparam int FILL_RUN        = 72;   // more than enough adds to fill the store
   localparam int DRAIN_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int Q16_UNIT        = 65536;
   localparam int COORD_MAX       = (1 << (COORD_W - 1)) - 1;
   localparam int COORD_MIN       = -(1 << (COORD_W - 1));

   // Q16 unit directions around the octagon, x and z components
   localparam int OCT_DX [8] = '{Q16_UNIT, Q16_DIAG, 0, -Q16_DIAG,
                                 -Q16_UNIT, -Q16_DIAG, 0, Q16_DIAG};
   localparam int OCT_DZ [8] = '{0, Q16_DIAG, Q16_UNIT, Q16_DIAG,
                                 0, -Q16_DIAG, -Q16_UNIT, -Q16_DIAG};

   typedef struct {
      logic                       command;
      logic signed [CENTER_W-1:0] center_x;
      logic signed [CENTER_W-1:0] center_z;
      logic signed [HEIGHT_W-1:0] bottom_y;
      logic signed [HEIGHT_W-1:0] top_y;
      logic signed [CENTER_W-1:0] radius;
      bit                         drain_first;
   } cyl_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid    = 1'b0;
   logic                       req_stall;
   logic                       req_command  = CMD_CLEAR;
   logic signed [CENTER_W-1:0] req_center_x = '0;
   logic signed [CENTER_W-1:0] req_center_z = '0;
   logic signed [HEIGHT_W-1:0] req_bottom_y = '0;
   logic signed [HEIGHT_W-1:0] req_top_y    = '0;
   logic signed [CENTER_W-1:0] req_radius   = '0;
   logic                       rsp_valid;
   logic                       rsp_stall    = 1'b0;
   logic [INDEX_W-1:0]         rsp_tri_index;
   logic signed [COORD_W-1:0]  rsp_v0_x, rsp_v0_y, rsp_v0_z;
   logic signed [COORD_W-1:0]  rsp_v1_x, rsp_v1_y, rsp_v1_z;
   logic signed [COORD_W-1:0]  rsp_v2_x, rsp_v2_y, rsp_v2_z;
   logic                       rsp_last;

   cyl_req_type       cyl_queue [$];
   cyl_req_type       cur_req;
   tri_type           pending_tris [$];
   logic [COUNT_W-1:0] tri_count = '0;
   int                total_reqs = 0;
   int                reqs_taken = 0;
   int                idle_cycles = 0;
   int                errors = 0;

   cylinder_to_octagonal_prism_triangles_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_center_x  (req_center_x),
      .req_center_z  (req_center_z),
      .req_bottom_y  (req_bottom_y),
      .req_top_y     (req_top_y),
      .req_radius    (req_radius),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tri_index (rsp_tri_index),
      .rsp_v0_x      (rsp_v0_x),
      .rsp_v0_y      (rsp_v0_y),
      .rsp_v0_z      (rsp_v0_z),
      .rsp_v1_x      (rsp_v1_x),
      .rsp_v1_y      (rsp_v1_y),
      .rsp_v1_z      (rsp_v1_z),
      .rsp_v2_x      (rsp_v2_x),
      .rsp_v2_y      (rsp_v2_y),
      .rsp_v2_z      (rsp_v2_z),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic signed [COORD_W:0] got,
                              input logic signed [COORD_W:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
      if (v > COORD_MAX) begin
         v = COORD_MAX;
      end else if (v < COORD_MIN) begin
         v = COORD_MIN;
      end
      return v[COORD_W-1:0];
   endfunction

   // (c + dir * r) * scale, with dir in Q16; SV division truncates toward zero
   function automatic logic signed [COORD_W-1:0] corner_coord(input int c, input int dir,
                                                              input int r);
      longint q;
      q = (longint'(c) * Q16_UNIT + longint'(dir) * longint'(r)) * WORLD_SCALE;
      return clamp_coord(q / Q16_UNIT);
   endfunction

   // Updates the triangle count and queues the triangles one transaction yields.
   function automatic void build_prism(input cyl_req_type c);
      logic signed [COORD_W-1:0] y_lo, y_hi, x0, z0, x1, z1;
      tri_type t;
      int j;
      if (c.command == CMD_CLEAR) begin
         tri_count = '0;
         return;
      end
      if (c.radius <= 0 || int'(tri_count) + TRI_PER_CYL > MAX_TRIANGLES) begin
         return;
      end
      y_lo = clamp_coord(longint'(c.bottom_y) * WORLD_SCALE);
      y_hi = clamp_coord(longint'(c.top_y) * WORLD_SCALE);
      for (int k = 0; k < 8; k++) begin
         j  = (k + 1) % 8;
         x0 = corner_coord(c.center_x, OCT_DX[k], c.radius);
         z0 = corner_coord(c.center_z, OCT_DZ[k], c.radius);
         x1 = corner_coord(c.center_x, OCT_DX[j], c.radius);
         z1 = corner_coord(c.center_z, OCT_DZ[j], c.radius);
         // lower triangle of the wall: B1, B0, T0
         t.tri_index = tri_count[INDEX_W-1:0];
         t.v0_x = x1; t.v0_y = y_lo; t.v0_z = z1;
         t.v1_x = x0; t.v1_y = y_lo; t.v1_z = z0;
         t.v2_x = x0; t.v2_y = y_hi; t.v2_z = z0;
         t.last = 1'b0;
         pending_tris.push_back(t);
         tri_count = tri_count + 1'b1;
         // upper triangle: B1, T0, T1
         t.tri_index = tri_count[INDEX_W-1:0];
         t.v1_y = y_hi;
         t.v2_x = x1; t.v2_z = z1;
         t.last = (k == 7);
         pending_tris.push_back(t);
         tri_count = tri_count + 1'b1;
      end
   endfunction

   function automatic void push_cyl(input logic cmd, input int cx, input int cz, input int by,
                                    input int ty, input int r, input bit drain);
      cyl_req_type c;
      c.command     = cmd;
      c.center_x    = cx[CENTER_W-1:0];
      c.center_z    = cz[CENTER_W-1:0];
      c.bottom_y    = by[HEIGHT_W-1:0];
      c.top_y       = ty[HEIGHT_W-1:0];
      c.radius      = r[CENTER_W-1:0];
      c.drain_first = drain;
      cyl_queue.push_back(c);
   endfunction

   function automatic void push_random(input logic cmd, input bit nonpos, input bit drain);
      int r;
      if (nonpos) begin
         r = -int'($urandom_range(32768, 0));
      end else if ($urandom_range(1, 0) == 0) begin
         r = $urandom_range(64, 1);
      end else begin
         r = $urandom_range(32767, 1);
      end
      push_cyl(cmd, $urandom(), $urandom(), $urandom(), $urandom(), r, drain);
   endfunction

   // 0: sender light idle / receiver heavy, 1: the reverse, 2: no idling
   function automatic int idle_phase();
      if (reqs_taken < total_reqs / 3) begin
         return 0;
      end else if (reqs_taken < (2 * total_reqs) / 3) begin
         return 1;
      end
      return 2;
   endfunction

   // request driver
   always @(posedge clock) begin
      bit sender_idle;
      bit held;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            build_prism(cur_req);
            reqs_taken++;
         end
         if (!req_valid || !req_stall) begin
            case (idle_phase())
               0:       sender_idle = ($urandom_range(99, 0) < 24);
               1:       sender_idle = ($urandom_range(99, 0) < 69);
               default: sender_idle = 1'b0;
            endcase
            held = cyl_queue.size() != 0 && cyl_queue[0].drain_first &&
                   pending_tris.size() != 0;
            if (cyl_queue.size() != 0 && !sender_idle && !held) begin
               cur_req = cyl_queue.pop_front();
               req_command  <= cur_req.command;
               req_center_x <= cur_req.center_x;
               req_center_z <= cur_req.center_z;
               req_bottom_y <= cur_req.bottom_y;
               req_top_y    <= cur_req.top_y;
               req_radius   <= cur_req.radius;
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      tri_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_tris.size() == 0) begin
               report_error($sformatf("unexpected triangle, tri_index %0d", rsp_tri_index));
            end else begin
               want = pending_tris.pop_front();
               check_field("tri_index", (COORD_W + 1)'(rsp_tri_index),
                           (COORD_W + 1)'(want.tri_index));
               check_field("v0_x", (COORD_W + 1)'(rsp_v0_x), (COORD_W + 1)'(want.v0_x));
               check_field("v0_y", (COORD_W + 1)'(rsp_v0_y), (COORD_W + 1)'(want.v0_y));
               check_field("v0_z", (COORD_W + 1)'(rsp_v0_z), (COORD_W + 1)'(want.v0_z));
               check_field("v1_x", (COORD_W + 1)'(rsp_v1_x), (COORD_W + 1)'(want.v1_x));
               check_field("v1_y", (COORD_W + 1)'(rsp_v1_y), (COORD_W + 1)'(want.v1_y));
               check_field("v1_z", (COORD_W + 1)'(rsp_v1_z), (COORD_W + 1)'(want.v1_z));
               check_field("v2_x", (COORD_W + 1)'(rsp_v2_x), (COORD_W + 1)'(want.v2_x));
               check_field("v2_y", (COORD_W + 1)'(rsp_v2_y), (COORD_W + 1)'(want.v2_y));
               check_field("v2_z", (COORD_W + 1)'(rsp_v2_z), (COORD_W + 1)'(want.v2_z));
               check_field("last", (COORD_W + 1)'(rsp_last), (COORD_W + 1)'(want.last));
            end
         end
         case (idle_phase())
            0:       rsp_stall <= ($urandom_range(99, 0) < 69);
            1:       rsp_stall <= ($urandom_range(99, 0) < 24);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int  adds_made;
      int  seg_len;
      bit  fill_run;
      // directed: extremes, drops, inverted heights, truncation of negatives
      push_cyl(CMD_CLEAR, 0, 0, 0, 0, 0, 1'b0);
      push_cyl(CMD_ADD, 100, -200, 0, 50, 10, 1'b0);
      push_cyl(CMD_ADD, 0, 0, 0, 1, 1, 1'b0);
      push_cyl(CMD_ADD, 32767, -32768, -131072, 131071, 32767, 1'b0);
      push_cyl(CMD_ADD, -32768, 32767, 131071, -131072, 32767, 1'b0);
      push_cyl(CMD_ADD, 32767, 32767, 131071, 131071, 32767, 1'b0);
      push_cyl(CMD_ADD, -32768, -32768, -131072, -131072, 32767, 1'b0);
      push_cyl(CMD_ADD, 5, 5, 0, 10, 0, 1'b0);
      push_cyl(CMD_ADD, 5, 5, 0, 10, -1, 1'b0);
      push_cyl(CMD_ADD, -1, -1, -1, -1, -32768, 1'b0);
      push_cyl(CMD_ADD, -1, 1, -7, 7, 3, 1'b0);
      push_cyl(CMD_ADD, 0, 0, 20, 20, 7, 1'b0);
      push_cyl(CMD_ADD, -3, -3, 1000, -1000, 1, 1'b0);
      push_cyl(CMD_ADD, 12345, -23456, 65535, -65536, 16383, 1'b0);
      push_cyl(CMD_CLEAR, -1, -1, -1, -1, -1, 1'b0);
      push_cyl(CMD_ADD, -21846, 21845, -87382, 87381, 21845, 1'b0);
      push_cyl(CMD_ADD, 21845, -21846, 87381, -87382, 10922, 1'b0);
      push_cyl(CMD_ADD, 1, -1, 131071, 131071, 2, 1'b0);

      // random: runs of adds with random content, led by a clear most of the time;
      // the first run is long enough to fill the store and see drops
      adds_made = 0;
      fill_run  = 1'b1;
      while (adds_made < RANDOM_ADDS) begin
         seg_len = fill_run ? FILL_RUN : $urandom_range(24, 1);
         if (fill_run || $urandom_range(9, 0) < 7) begin
            push_random(CMD_CLEAR, 1'($urandom_range(1, 0)),
                        fill_run || $urandom_range(3, 0) == 0);
         end
         for (int i = 0; i < seg_len; i++) begin
            if (!fill_run && $urandom_range(99, 0) < 8) begin
               push_random(CMD_ADD, 1'b1, 1'b0);
            end else begin
               push_random(CMD_ADD, 1'b0, 1'b0);
               adds_made++;
            end
         end
         fill_run = 1'b0;
      end
      total_reqs = cyl_queue.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (cyl_queue.size() != 0 || req_valid || pending_tris.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_tris.size() != 0) begin
         report_error($sformatf("%0d triangles never arrived", pending_tris.size()));
      end
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
